/* hdl/bdeque_pkg.sv */
// Shared definitions for the bounded deque with search.
// Holds operation codes, status codes and field widths; no dependencies.
package bdeque_pkg;

  localparam int DEPTH_DEF = 16;
  localparam int WORD_W    = 32;
  localparam int CNT_W     = 5;
  localparam int FUNC_W    = 3;
  localparam int STAT_W    = 2;

  localparam logic [CNT_W-1:0] CAP_RESET = 5'd16;

  localparam logic [FUNC_W-1:0] F_PUSH_FRONT = 3'd0;
  localparam logic [FUNC_W-1:0] F_PUSH_BACK  = 3'd1;
  localparam logic [FUNC_W-1:0] F_POP_BACK   = 3'd2;
  localparam logic [FUNC_W-1:0] F_POP_FRONT  = 3'd3;
  localparam logic [FUNC_W-1:0] F_SEARCH     = 3'd4;

  localparam logic [STAT_W-1:0] ST_DONE  = 2'd0;
  localparam logic [STAT_W-1:0] ST_FULL  = 2'd1;
  localparam logic [STAT_W-1:0] ST_EMPTY = 2'd2;

endpackage

/* hdl/bounded_deque_with_search_top.sv */
// Bounded deque with search: push/pop at both ends of a ring store, linear search.
// Pushes, pop front, pop back of the only word and other single-step cases go straight
// to emit; pop back passes read and check when words remain (one store read for the new back
// word); search passes read and check once per word visited. A result not yet taken holds
// the block in emit. Synchronous reset empties the list and sets capacity to 16; store contents
// are not cleared. Depends on bdeque_pkg.
module bounded_deque_with_search_top #(
  parameter int DEPTH = bdeque_pkg::DEPTH_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_wr_en,
  input  logic [bdeque_pkg::CNT_W-1:0]        cfg_wr_data,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [bdeque_pkg::FUNC_W-1:0]       func,
  input  logic signed [bdeque_pkg::WORD_W-1:0] value,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [bdeque_pkg::STAT_W-1:0]       status,
  output logic signed [bdeque_pkg::WORD_W-1:0] popped_value,
  output logic                                found,
  output logic [bdeque_pkg::CNT_W-1:0]        count,
  output logic                                is_empty,
  output logic                                is_full,
  output logic signed [bdeque_pkg::WORD_W-1:0] last_value,
  output logic                                last_valid
);
  import bdeque_pkg::*;

  localparam int IW      = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int SW      = ((IW > CNT_W) ? IW : CNT_W) + 1;
  localparam int CAP_MAX = (DEPTH < 31) ? DEPTH : 31;
  localparam logic [CNT_W-1:0] CAP_LIM   = CNT_W'(CAP_MAX);
  localparam logic [IW-1:0]    LAST_SLOT = IW'(DEPTH - 1);
  localparam logic [SW-1:0]    DEPTH_S   = SW'(DEPTH);

  typedef enum logic [2:0] {S_IDLE, S_READ, S_CHECK, S_EMIT} state_t;

  state_t                    state;
  logic [CNT_W-1:0]          capacity;
  logic [IW-1:0]             front_index;
  logic [CNT_W-1:0]          word_count;
  logic [CNT_W-1:0]          idx;
  logic                      is_search;
  logic signed [WORD_W-1:0]  last;
  logic signed [WORD_W-1:0]  popped;
  logic signed [WORD_W-1:0]  sval;
  logic [STAT_W-1:0]         st;
  logic                      fnd;

  logic signed [WORD_W-1:0]  mem [DEPTH];
  logic signed [WORD_W-1:0]  rdata;

  logic [CNT_W-1:0]          eff_cap;
  logic                      cap_full;
  logic                      accept;
  logic [CNT_W-1:0]          slot_idx;
  logic [SW-1:0]             slot_sum;
  logic [IW-1:0]             slot_addr;
  logic [IW-1:0]             front_dec;
  logic [IW-1:0]             front_inc;
  logic                      mem_we;
  logic [IW-1:0]             mem_waddr;

  assign in_ready = (state == S_IDLE);
  assign accept   = in_valid && in_ready;
  assign eff_cap  = (capacity > CAP_LIM) ? CAP_LIM : capacity;
  assign cap_full = (word_count >= eff_cap);

  // Shared ring-slot adder: the back slot for push back, otherwise the walk index.
  always_comb begin
    slot_idx  = (state == S_IDLE) ? word_count : idx;
    slot_sum  = SW'(front_index) + SW'(slot_idx);
    slot_addr = (slot_sum >= DEPTH_S) ? IW'(slot_sum - DEPTH_S) : IW'(slot_sum);
    front_dec = (front_index == '0) ? LAST_SLOT : front_index - 1'b1;
    front_inc = (front_index == LAST_SLOT) ? '0 : front_index + 1'b1;
    mem_we    = accept && !cap_full && ((func == F_PUSH_FRONT) || (func == F_PUSH_BACK));
    mem_waddr = (func == F_PUSH_FRONT) ? front_dec : slot_addr;
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= value;
    end
    rdata <= mem[slot_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      capacity    <= CAP_RESET;
      front_index <= '0;
      word_count  <= '0;
      out_valid   <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        capacity <= cfg_wr_data;
      end
      // In emit, a taken result is replaced by the new one below.
      if (out_valid && out_ready && (state != S_EMIT)) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            st     <= ST_DONE;
            popped <= '0;
            fnd    <= 1'b0;
            sval   <= value;
            state  <= S_EMIT;
            case (func)
              F_PUSH_FRONT: begin
                if (cap_full) begin
                  st <= ST_FULL;
                end else begin
                  front_index <= front_dec;
                  word_count  <= word_count + 1'b1;
                  // The front word is also the back word only when the list was empty.
                  if (word_count == '0) begin
                    last <= value;
                  end
                end
              end
              F_PUSH_BACK: begin
                if (cap_full) begin
                  st <= ST_FULL;
                end else begin
                  word_count <= word_count + 1'b1;
                  last       <= value;
                end
              end
              F_POP_BACK: begin
                if (word_count == '0) begin
                  st <= ST_EMPTY;
                end else begin
                  popped     <= last;
                  word_count <= word_count - 1'b1;
                  // Fetch the new back word from the store when words remain.
                  if (word_count > CNT_W'(1)) begin
                    idx       <= word_count - CNT_W'(2);
                    is_search <= 1'b0;
                    state     <= S_READ;
                  end
                end
              end
              F_POP_FRONT: begin
                if (word_count == '0) begin
                  st <= ST_EMPTY;
                end else begin
                  front_index <= front_inc;
                  word_count  <= word_count - 1'b1;
                end
              end
              F_SEARCH: begin
                if (word_count != '0) begin
                  idx       <= '0;
                  is_search <= 1'b1;
                  state     <= S_READ;
                end
              end
              default: begin
              end
            endcase
          end
        end
        S_READ: begin
          state <= S_CHECK;
        end
        S_CHECK: begin
          if (!is_search) begin
            last  <= rdata;
            state <= S_EMIT;
          end else if (rdata == sval) begin
            fnd   <= 1'b1;
            state <= S_EMIT;
          end else if (idx == word_count - 1'b1) begin
            state <= S_EMIT;
          end else begin
            idx   <= idx + 1'b1;
            state <= S_READ;
          end
        end
        S_EMIT: begin
          if (!out_valid || out_ready) begin
            out_valid    <= 1'b1;
            status       <= st;
            popped_value <= popped;
            found        <= fnd;
            count        <= word_count;
            is_empty     <= (word_count == '0);
            is_full      <= cap_full;
            last_value   <= (word_count != '0) ? last : '0;
            last_valid   <= (word_count != '0);
            state        <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule
